>>> hdl/key_value_reply_parser_unit_assert.svh
// Assertion macros for the key/value reply parser checker.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef KEY_VALUE_REPLY_PARSER_UNIT_ASSERT_SVH
`define KEY_VALUE_REPLY_PARSER_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define KVRP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kvrp assertion failed");

// next-cycle implication, disabled in reset
`define KVRP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kvrp assertion failed");

`endif

>>> hdl/kvrp_pkg.sv
// Shared types, constants and key lookup for the key/value reply parser.
// No dependencies.
package kvrp_pkg;

    localparam int VALUE_BITS     = 16;
    localparam int POSITION_LIMIT = 127;
    localparam int POS_BITS       = $clog2(POSITION_LIMIT + 1);
    localparam int PROD_BITS      = VALUE_BITS + 4;
    localparam int KEY_BITS       = 4;

    localparam logic [VALUE_BITS-1:0] MAG_CAP     = VALUE_BITS'(1) << (VALUE_BITS - 1);
    localparam logic [VALUE_BITS-1:0] POS_MAX_VAL = MAG_CAP - VALUE_BITS'(1);

    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [KEY_BITS-1:0] KEY_OX      = 4'd0;
    localparam logic [KEY_BITS-1:0] KEY_OY      = 4'd1;
    localparam logic [KEY_BITS-1:0] KEY_BX      = 4'd2;
    localparam logic [KEY_BITS-1:0] KEY_BY      = 4'd3;
    localparam logic [KEY_BITS-1:0] KEY_YX      = 4'd4;
    localparam logic [KEY_BITS-1:0] KEY_YY      = 4'd5;
    localparam logic [KEY_BITS-1:0] KEY_BI      = 4'd6;
    localparam logic [KEY_BITS-1:0] KEY_YI      = 4'd7;
    localparam logic [KEY_BITS-1:0] KEY_UNKNOWN = 4'd8;

    typedef enum logic [1:0] {
        NUM_SKIP,
        NUM_SIGN,
        NUM_DIGITS,
        NUM_DONE
    } t_num_phase;

    typedef struct packed {
        logic [KEY_BITS-1:0]          key_code;
        logic signed [VALUE_BITS-1:0] field_value;
        logic                         frame_end;
    } t_result;

    function automatic logic [KEY_BITS-1:0] key_lookup(input logic [7:0] c0,
                                                       input logic [7:0] c1);
        logic [KEY_BITS-1:0] code;
        case ({c0, c1})
            "ox":    code = KEY_OX;
            "oy":    code = KEY_OY;
            "bx":    code = KEY_BX;
            "by":    code = KEY_BY;
            "yx":    code = KEY_YX;
            "yy":    code = KEY_YY;
            "bi":    code = KEY_BI;
            "yi":    code = KEY_YI;
            default: code = KEY_UNKNOWN;
        endcase
        return code;
    endfunction

endpackage

>>> hdl/kvrp_seg.sv
// Segment state and one-byte update of the key/value reply parser.
// Depends on kvrp_pkg.
module kvrp_seg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_char,
    input  logic             i_last,
    output logic             o_emit,
    output kvrp_pkg::t_result o_result
);
    import kvrp_pkg::*;

    logic                   r_await, n_await;
    logic [POS_BITS-1:0]    r_pos, n_pos;
    logic [7:0]             r_key0, n_key0;
    logic [7:0]             r_key1, n_key1;
    logic                   r_colon2, n_colon2;
    t_num_phase             r_phase, n_phase;
    logic                   r_neg, n_neg;
    logic [VALUE_BITS-1:0]  r_mag, n_mag;

    logic                   is_digit;
    logic                   is_blank;
    logic [PROD_BITS-1:0]   prod;
    logic [VALUE_BITS-1:0]  dig_mag;

    assign is_digit = (i_char >= CHAR_ZERO) && (i_char <= CHAR_NINE);
    assign is_blank = (i_char == CHAR_SPACE) || (i_char inside {[8'd9:8'd13]});
    assign prod     = (PROD_BITS'(r_mag) << 3) + (PROD_BITS'(r_mag) << 1)
                    + PROD_BITS'(i_char - CHAR_ZERO);
    assign dig_mag  = (prod > PROD_BITS'(MAG_CAP)) ? MAG_CAP : prod[VALUE_BITS-1:0];

    always_comb begin
        n_await  = r_await;
        n_pos    = r_pos;
        n_key0   = r_key0;
        n_key1   = r_key1;
        n_colon2 = r_colon2;
        n_phase  = r_phase;
        n_neg    = r_neg;
        n_mag    = r_mag;
        if (i_step) begin
            if (r_await || i_last || (i_char == CHAR_HASH)) begin
                n_pos    = '0;
                n_key0   = '0;
                n_key1   = '0;
                n_colon2 = 1'b0;
                n_phase  = NUM_SKIP;
                n_neg    = 1'b0;
                n_mag    = '0;
                n_await  = r_await ? i_last : i_last;
            end else begin
                if (r_pos == POS_BITS'(0)) begin
                    n_key0 = i_char;
                end
                if (r_pos == POS_BITS'(1)) begin
                    n_key1 = i_char;
                end
                if (i_char == CHAR_COLON) begin
                    n_colon2 = (r_pos == POS_BITS'(2));
                end
                if (r_pos >= POS_BITS'(3)) begin
                    case (r_phase)
                        NUM_SKIP: begin
                            if (is_blank) begin
                                n_phase = NUM_SKIP;
                            end else if ((i_char == CHAR_PLUS) || (i_char == CHAR_MINUS)) begin
                                n_neg   = (i_char == CHAR_MINUS);
                                n_phase = NUM_SIGN;
                            end else if (is_digit) begin
                                n_mag   = dig_mag;
                                n_phase = NUM_DIGITS;
                            end else begin
                                n_phase = NUM_DONE;
                            end
                        end
                        NUM_SIGN, NUM_DIGITS: begin
                            if (is_digit) begin
                                n_mag   = dig_mag;
                                n_phase = NUM_DIGITS;
                            end else begin
                                n_phase = NUM_DONE;
                            end
                        end
                        default: n_phase = NUM_DONE;
                    endcase
                end
                if (r_pos < POS_BITS'(POSITION_LIMIT)) begin
                    n_pos = r_pos + POS_BITS'(1);
                end
            end
        end
    end

    always_comb begin
        o_emit               = i_step && (i_last || (!r_await && (i_char == CHAR_HASH)));
        o_result.key_code    = r_colon2 ? key_lookup(r_key0, r_key1) : KEY_UNKNOWN;
        o_result.field_value = r_neg ? (VALUE_BITS'(0) - r_mag)
                             : ((r_mag > POS_MAX_VAL) ? POS_MAX_VAL : r_mag);
        o_result.frame_end   = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await  <= 1'b1;
            r_pos    <= '0;
            r_key0   <= '0;
            r_key1   <= '0;
            r_colon2 <= 1'b0;
            r_phase  <= NUM_SKIP;
            r_neg    <= 1'b0;
            r_mag    <= '0;
        end else begin
            r_await  <= n_await;
            r_pos    <= n_pos;
            r_key0   <= n_key0;
            r_key1   <= n_key1;
            r_colon2 <= n_colon2;
            r_phase  <= n_phase;
            r_neg    <= n_neg;
            r_mag    <= n_mag;
        end
    end

endmodule

>>> hdl/key_value_reply_parser_unit.sv
// Top level of the key/value reply parser: input word register, segment
// update, result register. Depends on kvrp_pkg and kvrp_seg.
//
// Takes one reply byte per clock and gives one result word for every
// segment closed by '#' or by the final byte of a frame; the opening byte
// of a frame is dropped. A result word passes the input register and then
// the result register on its way to the output, and can be taken at the
// following edge once it is there. The segment state updates once per byte,
// so bytes are accepted back to back while the output is ready. While a
// result waits on a stalled output, the input register takes at most one
// more byte and then holds until the result word is taken.
module key_value_reply_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_byte
    input  logic        i_s_tlast,   // frame_last
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [3:0] key_code, [19:4] field_value, [23:20] zero
    output logic        o_m_tlast    // frame_end
);
    import kvrp_pkg::*;

    localparam int OUT_BITS = 24;
    localparam int PAY_BITS = KEY_BITS + VALUE_BITS;

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;

    logic       advance;
    logic       step;
    logic       emit;
    t_result    result;

    assign advance    = !r_out_valid || i_m_tready;
    assign step       = r_in_valid && advance;
    assign o_s_tready = !r_in_valid || advance;

    kvrp_seg u_seg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_char   (r_in_char),
        .i_last   (r_in_last),
        .o_emit   (emit),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_char <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_BITS - PAY_BITS)'(0), r_out.field_value, r_out.key_code};
    assign o_m_tlast  = r_out.frame_end;

endmodule

>>> hdl/kvrp_checker.sv
// Port-level checks for key_value_reply_parser_unit, bound to the top level.
// Depends on key_value_reply_parser_unit_assert.svh.
`include "key_value_reply_parser_unit_assert.svh"

module kvrp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic        o_m_tlast
);

    logic m_stall;

    assign m_stall = o_m_tvalid && !i_m_tready;

    `KVRP_ASSERT_NOW(a_key_range, o_m_tvalid, o_m_tdata[3:0] <= 4'd8)
    `KVRP_ASSERT_NOW(a_pad_zero, o_m_tvalid, o_m_tdata[23:20] == 4'd0)
    `KVRP_ASSERT_NOW(a_fresh_result, $rose(o_m_tvalid), $past(i_s_tvalid && o_s_tready, 2))
    `KVRP_ASSERT_NEXT(a_stall_hold, m_stall, o_m_tvalid && $stable({o_m_tdata, o_m_tlast}))

endmodule

bind key_value_reply_parser_unit kvrp_checker u_kvrp_checker (.*);
